@@ rtl/mfde_pkg.sv @@
package mfde_pkg;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] x_first;
        logic [7:0] y_first;
        logic [7:0] x_second;
        logic [7:0] y_second;
        logic [5:0] radius;
        logic       color;
        logic [9:0] byte_index;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic       clipped;
    } t_result;

    localparam logic [2:0] ACT_PIXEL   = 3'd0;
    localparam logic [2:0] ACT_LINE    = 3'd1;
    localparam logic [2:0] ACT_RECT_O  = 3'd2;
    localparam logic [2:0] ACT_RECT_F  = 3'd3;
    localparam logic [2:0] ACT_CIRC_O  = 3'd4;
    localparam logic [2:0] ACT_CIRC_F  = 3'd5;
    localparam logic [2:0] ACT_READ    = 3'd6;
    localparam logic [2:0] ACT_NONE    = 3'd7;

    localparam logic [7:0] MSB_MASK = 8'h80;

endpackage

@@ rtl/mfde_front.sv @@
// command queue between the accepting side and the raster engine
module mfde_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  mfde_pkg::t_cmd  i_cmd,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output mfde_pkg::t_cmd  o_q_cmd
);
    import mfde_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_mem[r_rp];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

@@ rtl/mfde_back.sv @@
// raster engine: shape sequencer, line stepper, byte read-modify-write
module mfde_back #(
    parameter int SCREEN_WIDTH  = 144,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  mfde_pkg::t_cmd    i_q_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output mfde_pkg::t_result o_result
);
    import mfde_pkg::*;

    localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;
    localparam int AW          = $clog2(STORE_BYTES);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_CLR   = 4'd1;
    localparam logic [3:0] ST_SHAPE = 4'd2;
    localparam logic [3:0] ST_LSET  = 4'd3;
    localparam logic [3:0] ST_LRUN  = 4'd4;
    localparam logic [3:0] ST_RD    = 4'd5;
    localparam logic [3:0] ST_WR    = 4'd6;
    localparam logic [3:0] ST_CSTEP = 4'd7;
    localparam logic [3:0] ST_RDB   = 4'd8;
    localparam logic [3:0] ST_RDB2  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    logic [7:0]    r_mem [STORE_BYTES];
    logic [7:0]    r_rdata;
    logic [3:0]    r_st;
    logic [AW-1:0] r_clr;
    t_cmd          r_cmd;
    logic          r_clip;
    logic [7:0]    r_rdout;
    // shape sequencer
    logic [2:0]    r_sub;     // sub index: rect edge, circle line/plot
    logic [7:0]    r_row;
    logic [6:0]    r_ca, r_cb;
    logic signed [15:0] r_ce;
    // line stepper
    logic [7:0]    r_la_x, r_la_y, r_lb_x, r_lb_y;
    logic [7:0]    r_x, r_y;
    logic [8:0]    r_n, r_major, r_minor;
    logic          r_xmaj, r_sxn, r_syn, r_single;
    logic signed [10:0] r_e;
    // store access
    logic [AW-1:0] r_addr;
    logic [7:0]    r_mask;
    logic          r_wen;
    logic          r_do_rd;

    logic [7:0] w_dx, w_dy;
    logic       w_in;
    logic [15:0] w_idx;
    logic [7:0] ax, ay, bx, by, cxpa, cxma, cxpb, cxmb, cypa, cyma, cypb, cymb;
    logic [7:0] w_ca8, w_cb8;

    assign w_ca8 = {1'b0, r_ca};
    assign w_cb8 = {1'b0, r_cb};
    assign cxpa = r_cmd.x_first + w_ca8;
    assign cxma = r_cmd.x_first - w_ca8;
    assign cxpb = r_cmd.x_first + w_cb8;
    assign cxmb = r_cmd.x_first - w_cb8;
    assign cypa = r_cmd.y_first + w_ca8;
    assign cyma = r_cmd.y_first - w_ca8;
    assign cypb = r_cmd.y_first + w_cb8;
    assign cymb = r_cmd.y_first - w_cb8;

    // line endpoints (or single point) for the current sub step
    always_comb begin
        ax = r_cmd.x_first; ay = r_cmd.y_first;
        bx = r_cmd.x_second; by = r_cmd.y_second;
        unique case (r_cmd.action)
            ACT_LINE: begin
            end
            ACT_RECT_O: begin
                unique case (r_sub[1:0])
                    2'd0: begin ay = r_cmd.y_first;  by = r_cmd.y_first;  end
                    2'd1: begin ay = r_cmd.y_second; by = r_cmd.y_second; end
                    2'd2: begin bx = r_cmd.x_first;  end
                    default: begin ax = r_cmd.x_second; end
                endcase
            end
            ACT_RECT_F: begin ay = r_row; by = r_row; end
            ACT_CIRC_F: begin
                unique case (r_sub[1:0])
                    2'd0: begin ax = cxma; bx = cxpa; ay = cypb; end
                    2'd1: begin ax = cxma; bx = cxpa; ay = cymb; end
                    2'd2: begin ax = cxmb; bx = cxpb; ay = cypa; end
                    default: begin ax = cxmb; bx = cxpb; ay = cyma; end
                endcase
                by = ay;
            end
            ACT_CIRC_O: begin
                unique case (r_sub)
                    3'd0: begin ax = cxpa; ay = cypb; end
                    3'd1: begin ax = cxpb; ay = cypa; end
                    3'd2: begin ax = cxma; ay = cypb; end
                    3'd3: begin ax = cxmb; ay = cypa; end
                    3'd4: begin ax = cxpb; ay = cyma; end
                    3'd5: begin ax = cxpa; ay = cymb; end
                    3'd6: begin ax = cxma; ay = cymb; end
                    default: begin ax = cxmb; ay = cyma; end
                endcase
                bx = ax; by = ay;
            end
            default: begin bx = ax; by = ay; end
        endcase
    end

    assign w_dx  = (r_lb_x > r_la_x) ? r_lb_x - r_la_x : r_la_x - r_lb_x;
    assign w_dy  = (r_lb_y > r_la_y) ? r_lb_y - r_la_y : r_la_y - r_lb_y;
    assign w_in  = (32'(r_x) < 32'(SCREEN_WIDTH)) && (32'(r_y) < 32'(SCREEN_HEIGHT));
    assign w_idx = 16'(r_y) * 16'(ROW_BYTES) + 16'(r_x[7:3]);

    assign o_q_ready        = (r_st == ST_IDLE);
    assign o_valid          = (r_st == ST_OUT);
    assign o_result.read_data = r_rdout;
    assign o_result.clipped   = r_clip;

    // frame store, one port
    always_ff @(posedge i_clk) begin
        if (r_wen) begin
            r_mem[r_addr] <= (r_cmd.color) ? (r_rdata | r_mask) : (r_rdata & ~r_mask);
        end else if (r_st == ST_CLR) begin
            r_mem[r_clr] <= 8'h00;
        end
        if (r_do_rd) r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_CLR;
            r_clr   <= '0;
            r_wen   <= 1'b0;
            r_do_rd <= 1'b0;
            r_clip  <= 1'b0;
            r_rdout <= 8'h00;
        end else begin
            r_wen   <= 1'b0;
            r_do_rd <= 1'b0;
            unique case (r_st)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == STORE_BYTES - 1) r_st <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_clip  <= 1'b0;
                        r_rdout <= 8'h00;
                        r_sub   <= 3'd0;
                        r_ca    <= 7'd0;
                        r_cb    <= {1'b0, i_q_cmd.radius};
                        r_ce    <= 16'sd1 - 16'(i_q_cmd.radius);
                        r_row   <= (i_q_cmd.y_first < i_q_cmd.y_second) ?
                                   i_q_cmd.y_first : i_q_cmd.y_second;
                        if (i_q_cmd.action == ACT_READ) r_st <= ST_RDB;
                        else if (i_q_cmd.action == ACT_NONE) r_st <= ST_OUT;
                        else r_st <= ST_SHAPE;
                    end
                end
                ST_RDB: begin
                    r_addr  <= AW'(r_cmd.byte_index);
                    r_do_rd <= (32'(r_cmd.byte_index) < STORE_BYTES);
                    r_st    <= ST_RDB2;
                end
                ST_RDB2: begin
                    if (!r_do_rd) begin
                        if (32'(r_cmd.byte_index) < STORE_BYTES) r_rdout <= r_rdata;
                        r_st <= ST_OUT;
                    end
                end
                ST_SHAPE: begin
                    r_la_x <= ax; r_la_y <= ay; r_lb_x <= bx; r_lb_y <= by;
                    r_single <= (r_cmd.action == ACT_PIXEL) || (r_cmd.action == ACT_CIRC_O);
                    r_st <= ST_LSET;
                end
                ST_LSET: begin
                    r_x <= r_la_x; r_y <= r_la_y;
                    r_xmaj <= (w_dx >= w_dy);
                    r_major <= (w_dx >= w_dy) ? {1'b0, w_dx} : {1'b0, w_dy};
                    r_minor <= (w_dx >= w_dy) ? {1'b0, w_dy} : {1'b0, w_dx};
                    r_e <= (w_dx >= w_dy) ? 11'(2 * 32'(w_dy) - 32'(w_dx))
                                          : 11'(2 * 32'(w_dx) - 32'(w_dy));
                    r_sxn <= (r_la_x > r_lb_x);
                    r_syn <= (r_la_y > r_lb_y);
                    r_n <= 9'd0;
                    r_st <= ST_LRUN;
                end
                ST_LRUN: begin
                    // plot current point: address, read
                    if (w_in) begin
                        r_addr  <= AW'(w_idx);
                        r_mask  <= MSB_MASK >> r_x[2:0];
                        r_do_rd <= 1'b1;
                        r_st    <= ST_RD;
                    end else begin
                        r_clip <= 1'b1;
                        r_st   <= ST_WR;
                    end
                end
                ST_RD: begin
                    r_wen <= 1'b1;
                    r_st  <= ST_WR;
                end
                ST_WR: begin
                    // advance line stepper
                    if (r_e < 0) begin
                        r_e <= r_e + 11'(2 * r_minor);
                        if (r_xmaj) r_x <= r_sxn ? r_x - 8'd1 : r_x + 8'd1;
                        else        r_y <= r_syn ? r_y - 8'd1 : r_y + 8'd1;
                    end else begin
                        r_e <= r_e + 11'(2 * r_minor) - 11'(2 * r_major);
                        r_x <= r_sxn ? r_x - 8'd1 : r_x + 8'd1;
                        r_y <= r_syn ? r_y - 8'd1 : r_y + 8'd1;
                    end
                    r_n <= r_n + 9'd1;
                    if (r_n == r_major || r_single) r_st <= ST_CSTEP;
                    else r_st <= ST_LRUN;
                end
                ST_CSTEP: begin
                    // finished one line or point: next of the shape
                    unique case (r_cmd.action)
                        ACT_RECT_O: begin
                            r_sub <= r_sub + 3'd1;
                            r_st  <= (r_sub == 3'd3) ? ST_OUT : ST_SHAPE;
                        end
                        ACT_RECT_F: begin
                            r_row <= r_row + 8'd1;
                            if (r_row == ((r_cmd.y_first < r_cmd.y_second) ?
                                    r_cmd.y_second : r_cmd.y_first))
                                r_st <= ST_OUT;
                            else r_st <= ST_SHAPE;
                        end
                        ACT_CIRC_O, ACT_CIRC_F: begin
                            if ((r_cmd.action == ACT_CIRC_O && r_sub == 3'd7) ||
                                (r_cmd.action == ACT_CIRC_F && r_sub == 3'd3)) begin
                                r_sub <= 3'd0;
                                if (r_ce < 0) begin
                                    r_ce <= r_ce + 16'sd3 + 16'({r_ca, 1'b0});
                                    r_ca <= r_ca + 7'd1;
                                    r_st <= (r_ca + 7'd1 > r_cb) ? ST_OUT : ST_SHAPE;
                                end else begin
                                    r_ce <= r_ce + 16'sd5 + 16'({r_ca, 1'b0})
                                            - 16'({r_cb, 1'b0});
                                    r_ca <= r_ca + 7'd1;
                                    r_cb <= r_cb - 7'd1;
                                    // b steps down too: a + 1 > b - 1, kept clear of b = 0
                                    r_st <= (r_ca + 7'd2 > r_cb) ? ST_OUT : ST_SHAPE;
                                end
                            end else begin
                                r_sub <= r_sub + 3'd1;
                                r_st  <= ST_SHAPE;
                            end
                        end
                        default: r_st <= ST_OUT;
                    endcase
                end
                ST_OUT: begin
                    if (i_ready) r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/mono_framebuffer_draw_engine_core.sv @@
// steps: each plotted pixel takes address, read and write-back of one store byte; a clipped
// pixel skips the read and the store write, and each line or point adds setup and shape step;
// a read-byte command addresses, reads and then returns one store byte
// throughput: one command at a time, set by the single-port frame store
// reset: a clearing pass of one store byte per cycle (576 store bytes at 144x32)
// runs after reset; commands queue in the two-entry front queue meanwhile
module mono_framebuffer_draw_engine_core #(
    parameter int SCREEN_WIDTH  = 144,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mfde_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output mfde_pkg::t_result o_result
);
    import mfde_pkg::*;

    // queue toward the raster engine
    logic q_valid, q_ready;
    t_cmd q_cmd;

    mfde_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_cmd   (q_cmd)
    );

    // raster engine holds the result beat until taken
    mfde_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_cmd   (q_cmd),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_result  (o_result)
    );
endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import mfde_pkg::*;

    localparam int WIDTH_PX    = 144;
    localparam int HEIGHT_PX   = 32;
    localparam int ROW_BYTES   = (WIDTH_PX + 7) / 8;
    localparam int STORE_BYTES = ROW_BYTES * HEIGHT_PX;
    localparam int N_RANDOM    = 1425;
    localparam int TAIL_CYCLES = 400;
    // worst case per command plus stalls stays well under this limit
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_ready;
    t_cmd    i_cmd;
    logic    o_valid;
    logic    i_ready;
    t_result o_result;

    mono_framebuffer_draw_engine_core DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    // command stream waiting to go out, and results owed by the engine
    t_cmd    cmd_backlog[$];
    t_result owed_results[$];

    // shadow of the frame store, updated as each beat is accepted
    logic [7:0] shadow_fb[STORE_BYTES];
    bit         shadow_clip;

    int     n_sent;
    int     n_total;
    int     n_checked;
    int     n_errors;
    int     per_action[8];
    longint cycle_count;
    bit     all_queued;

    // idle bursts: every so often both sides draw no random idle gaps at all
    bit     no_idle_phase;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch on result %0d: %s got %0d expected %0d", n_checked, what, got, want);
        n_errors++;
    endtask

    function automatic int idle_draw();
        if (no_idle_phase || $urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    // ---------------------------------------------------------------------
    // shadow rasterizer
    // ---------------------------------------------------------------------

    // one pixel write, off-screen writes only raise the clip flag
    function automatic void shade_pixel(input logic [7:0] x, input logic [7:0] y,
                                        input logic c);
        int idx;
        logic [7:0] bitmask;
        if (x >= WIDTH_PX || y >= HEIGHT_PX) begin
            shadow_clip = 1'b1;
        end else begin
            idx     = y * ROW_BYTES + (x >> 3);
            bitmask = MSB_MASK >> x[2:0];
            if (c) begin
                shadow_fb[idx] = shadow_fb[idx] | bitmask;
            end else begin
                shadow_fb[idx] = shadow_fb[idx] & ~bitmask;
            end
        end
    endfunction

    // bresenham with 8-bit wrapping steps, major+1 pixels
    function automatic void shade_line(input logic [7:0] xa, input logic [7:0] ya,
                                       input logic [7:0] xb, input logic [7:0] yb,
                                       input logic c);
        int dx;
        int dy;
        int major_len;
        int minor_len;
        int err;
        bit xmajor;
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] px;
        logic [7:0] py;
        dx        = (xb > xa) ? int'(xb) - int'(xa) : int'(xa) - int'(xb);
        dy        = (yb > ya) ? int'(yb) - int'(ya) : int'(ya) - int'(yb);
        sx        = (xa > xb) ? 8'hFF : 8'h01;
        sy        = (ya > yb) ? 8'hFF : 8'h01;
        xmajor    = (dx >= dy);
        major_len = xmajor ? dx : dy;
        minor_len = xmajor ? dy : dx;
        err       = 2 * minor_len - major_len;
        px        = xa;
        py        = ya;
        for (int n = 0; n <= major_len; n++) begin
            shade_pixel(px, py, c);
            if (err < 0) begin
                err += 2 * minor_len;
                if (xmajor) begin
                    px = px + sx;
                end else begin
                    py = py + sy;
                end
            end else begin
                err += 2 * minor_len - 2 * major_len;
                px = px + sx;
                py = py + sy;
            end
        end
    endfunction

    function automatic void shade_rect(input t_cmd cmd, input bit filled);
        int lo;
        int hi;
        if (filled) begin
            lo = (cmd.y_first < cmd.y_second) ? cmd.y_first : cmd.y_second;
            hi = (cmd.y_first < cmd.y_second) ? cmd.y_second : cmd.y_first;
            for (int r = lo; r <= hi; r++) begin
                shade_line(cmd.x_first, 8'(r), cmd.x_second, 8'(r), cmd.color);
            end
        end else begin
            shade_line(cmd.x_first, cmd.y_first, cmd.x_second, cmd.y_first, cmd.color);
            shade_line(cmd.x_first, cmd.y_second, cmd.x_second, cmd.y_second, cmd.color);
            shade_line(cmd.x_first, cmd.y_first, cmd.x_first, cmd.y_second, cmd.color);
            shade_line(cmd.x_second, cmd.y_first, cmd.x_second, cmd.y_second, cmd.color);
        end
    endfunction

    // midpoint circle, eight-way symmetric points or four spans per step
    function automatic void shade_circle(input t_cmd cmd, input bit filled);
        int a;
        int b;
        int err;
        logic [7:0] xpa, xma, xpb, xmb, ypa, yma, ypb, ymb;
        a   = 0;
        b   = cmd.radius;
        err = 1 - b;
        do begin
            xpa = cmd.x_first + 8'(a);
            xma = cmd.x_first - 8'(a);
            xpb = cmd.x_first + 8'(b);
            xmb = cmd.x_first - 8'(b);
            ypa = cmd.y_first + 8'(a);
            yma = cmd.y_first - 8'(a);
            ypb = cmd.y_first + 8'(b);
            ymb = cmd.y_first - 8'(b);
            if (filled) begin
                shade_line(xma, ypb, xpa, ypb, cmd.color);
                shade_line(xma, ymb, xpa, ymb, cmd.color);
                shade_line(xmb, ypa, xpb, ypa, cmd.color);
                shade_line(xmb, yma, xpb, yma, cmd.color);
            end else begin
                shade_pixel(xpa, ypb, cmd.color);
                shade_pixel(xpb, ypa, cmd.color);
                shade_pixel(xma, ypb, cmd.color);
                shade_pixel(xmb, ypa, cmd.color);
                shade_pixel(xpb, yma, cmd.color);
                shade_pixel(xpa, ymb, cmd.color);
                shade_pixel(xma, ymb, cmd.color);
                shade_pixel(xmb, yma, cmd.color);
            end
            if (err < 0) begin
                err += 3 + 2 * a;
                a++;
            end else begin
                err += 5 + 2 * (a - b);
                a++;
                b--;
            end
        end while (a <= b);
    endfunction

    // apply one command to the shadow store and return what the engine owes
    function automatic t_result rasterize_cmd(input t_cmd cmd);
        t_result res;
        res         = '0;
        shadow_clip = 1'b0;
        case (cmd.action)
            ACT_PIXEL:  shade_pixel(cmd.x_first, cmd.y_first, cmd.color);
            ACT_LINE:   shade_line(cmd.x_first, cmd.y_first, cmd.x_second, cmd.y_second,
                                   cmd.color);
            ACT_RECT_O: shade_rect(cmd, 1'b0);
            ACT_RECT_F: shade_rect(cmd, 1'b1);
            ACT_CIRC_O: shade_circle(cmd, 1'b0);
            ACT_CIRC_F: shade_circle(cmd, 1'b1);
            ACT_READ: begin
                if (cmd.byte_index < STORE_BYTES) begin
                    res.read_data = shadow_fb[cmd.byte_index];
                end
            end
            default: ;
        endcase
        res.clipped = shadow_clip;
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------------

    function automatic t_cmd make_cmd(input logic [2:0] act, input int xa, input int ya,
                                      input int xb, input int yb, input int rad,
                                      input int c, input int bidx);
        t_cmd cmd;
        cmd.action     = act;
        cmd.x_first    = 8'(xa);
        cmd.y_first    = 8'(ya);
        cmd.x_second   = 8'(xb);
        cmd.y_second   = 8'(yb);
        cmd.radius     = 6'(rad);
        cmd.color      = 1'(c);
        cmd.byte_index = 10'(bidx);
        return cmd;
    endfunction

    // random command, mostly on or near the screen and with modest sizes
    function automatic t_cmd random_cmd();
        t_cmd        cmd;
        logic [63:0] raw;
        int          pick;
        bit          near;
        raw        = {$urandom, $urandom};
        cmd        = raw[$bits(t_cmd)-1:0];
        pick       = $urandom_range(0, 99);
        near       = ($urandom_range(0, 6) != 0);
        cmd.color  = ($urandom_range(0, 3) != 0);
        if (near) begin
            cmd.x_first  = 8'($urandom_range(0, 159));
            cmd.y_first  = 8'($urandom_range(0, 39));
            cmd.x_second = 8'($urandom_range(0, 159));
            cmd.y_second = 8'($urandom_range(0, 39));
        end
        if (pick < 22) begin
            cmd.action = ACT_PIXEL;
        end else if (pick < 36) begin
            cmd.action = ACT_LINE;
        end else if (pick < 44) begin
            cmd.action = ACT_RECT_O;
        end else if (pick < 52) begin
            // keep filled rectangles short in both directions
            cmd.action   = ACT_RECT_F;
            cmd.x_second = cmd.x_first + 8'($urandom_range(0, 24)) - 8'd12;
            cmd.y_second = cmd.y_first + 8'($urandom_range(0, 10)) - 8'd5;
        end else if (pick < 60) begin
            cmd.action = ACT_CIRC_O;
            if ($urandom_range(0, 3) != 0) begin
                cmd.radius = 6'($urandom_range(0, 16));
            end
        end else if (pick < 67) begin
            cmd.action = ACT_CIRC_F;
            cmd.radius = 6'($urandom_range(0, 10));
        end else if (pick < 98) begin
            cmd.action = ACT_READ;
            if ($urandom_range(0, 4) != 0) begin
                cmd.byte_index = 10'($urandom_range(0, STORE_BYTES - 1));
            end
        end else begin
            cmd.action = ACT_NONE;
        end
        return cmd;
    endfunction

    initial begin
        n_sent        = 0;
        n_checked     = 0;
        n_errors      = 0;
        all_queued    = 1'b0;
        no_idle_phase = 1'b0;
        for (int k = 0; k < 8; k++) begin
            per_action[k] = 0;
        end

        // screen corners with a readback of each, and off-screen pixels
        cmd_backlog.push_back(make_cmd(ACT_PIXEL, 0, 0, 0, 0, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_PIXEL, 143, 31, 0, 0, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_PIXEL, 144, 0, 0, 0, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_PIXEL, 0, 32, 0, 0, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_PIXEL, 255, 255, 0, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, STORE_BYTES - 1));
        // store size and beyond read zero
        cmd_backlog.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, STORE_BYTES));
        cmd_backlog.push_back(make_cmd(ACT_READ, 255, 255, 255, 255, 63, 1, 1023));
        // full-length lines both ways
        cmd_backlog.push_back(make_cmd(ACT_LINE, 0, 5, 255, 5, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_LINE, 255, 255, 0, 0, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_LINE, 10, 30, 13, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 5 * ROW_BYTES + 3));
        cmd_backlog.push_back(make_cmd(ACT_RECT_O, 20, 2, 60, 28, 0, 1, 0));
        // filled rectangle over every row 0..255, kept narrow
        cmd_backlog.push_back(make_cmd(ACT_RECT_F, 30, 0, 33, 255, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_RECT_F, 100, 20, 90, 10, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 12 * ROW_BYTES + 3));
        cmd_backlog.push_back(make_cmd(ACT_CIRC_O, 72, 16, 0, 0, 63, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_CIRC_O, 72, 16, 0, 0, 0, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_CIRC_F, 72, 16, 0, 0, 0, 0, 0));
        // span left end wraps past zero
        cmd_backlog.push_back(make_cmd(ACT_CIRC_F, 2, 16, 0, 0, 5, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_CIRC_F, 120, 1, 0, 0, 12, 1, 0));
        cmd_backlog.push_back(make_cmd(ACT_READ, 0, 0, 0, 0, 0, 0, 16 * ROW_BYTES));
        // unused action
        cmd_backlog.push_back(make_cmd(ACT_NONE, 7, 7, 7, 7, 7, 1, 7));

        for (int k = 0; k < N_RANDOM; k++) begin
            cmd_backlog.push_back(random_cmd());
        end
        n_total    = cmd_backlog.size();
        all_queued = 1'b1;
    end

    // ---------------------------------------------------------------------
    // reset, cycle limit, end of run
    // ---------------------------------------------------------------------

    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (all_queued && n_sent == n_total && owed_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d commands sent, %0d results checked, %0d mismatches", n_sent, n_checked,
                 n_errors);
        $display("mix: pixel %0d line %0d rect %0d/%0d circle %0d/%0d read %0d unused %0d",
                 per_action[0], per_action[1], per_action[2], per_action[3], per_action[4],
                 per_action[5], per_action[6], per_action[7]);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycle_count,
                     owed_results.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        cycle_count = 0;
        i_valid     = 1'b0;
        i_cmd       = '0;
        i_ready     = 1'b0;
        foreach (shadow_fb[k]) begin
            shadow_fb[k] = 8'h00;
        end
    end

    // ---------------------------------------------------------------------
    // command driver
    // ---------------------------------------------------------------------

    int  send_gap;
    bit  drive_next;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid  <= 1'b0;
            send_gap <= idle_draw();
        end else begin
            drive_next = 1'b0;
            // a beat went in, so the shadow store moves on in the same order
            if (i_valid && o_ready) begin
                owed_results.push_back(rasterize_cmd(i_cmd));
                per_action[i_cmd.action]++;
                n_sent++;
                // switch idle behavior now and then for runs of back-to-back beats
                if (n_sent % 64 == 0) begin
                    no_idle_phase = ($urandom_range(0, 2) == 0);
                end
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (cmd_backlog.size() > 0) begin
                    drive_next = 1'b1;
                end
                if (drive_next) begin
                    i_cmd    <= cmd_backlog.pop_front();
                    send_gap <= idle_draw();
                end
                i_valid <= drive_next;
            end
        end
    end

    // ---------------------------------------------------------------------
    // result monitor with random back-pressure
    // ---------------------------------------------------------------------

    int      stall_left;
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && i_ready) begin
                if (owed_results.size() == 0) begin
                    $display("result beat with nothing owed");
                    n_errors++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_result.read_data !== want.read_data) begin
                        report("read_data", o_result.read_data, want.read_data);
                    end
                    if (o_result.clipped !== want.clipped) begin
                        report("clipped", o_result.clipped, want.clipped);
                    end
                end
                n_checked++;
                stall_left <= idle_draw();
                i_ready    <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_ready    <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

endmodule
